// ===== rtl/jlztb_pkg.sv =====
// Shared constants, codes and types for the joint limit zone torque blend block.
package jlztb_pkg;

    localparam int DEF_VALUE_WIDTH = 32;
    localparam int DEF_FRAC_BITS   = 16;
    localparam int RATIO_BITS      = 16;
    localparam int RATIO_W         = 17;
    localparam int IW              = 64;   // internal width, holds +-2^61 and its sums
    localparam int QUEUE_DEPTH     = 4;    // power of two
    localparam int CFG_IDX_W       = 3;

    localparam int RST_ENABLE      = 1;
    localparam int RST_POS_OUTER   = 13107;
    localparam int RST_POS_INNER   = 6554;
    localparam int RST_VEL_OUTER   = 13107;
    localparam int RST_VEL_INNER   = 6554;
    localparam int RST_DAMPING     = 655360;
    localparam int RST_POS_RATIO   = 32768;
    localparam int RST_VEL_RATIO   = 32768;

    localparam logic signed [IW-1:0] SAT_LIM = 64'sh2000_0000_0000_0000;

    typedef enum logic [2:0] {
        ZONE_OFF       = 3'd0,
        ZONE_POS_OUTER = 3'd1,
        ZONE_POS_INNER = 3'd2,
        ZONE_VEL_OUTER = 3'd3,
        ZONE_VEL_INNER = 3'd4
    } t_zone;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ENABLE    = 3'd0,
        CFG_POS_OUTER = 3'd1,
        CFG_POS_INNER = 3'd2,
        CFG_VEL_OUTER = 3'd3,
        CFG_VEL_INNER = 3'd4,
        CFG_DAMPING   = 3'd5,
        CFG_POS_RATIO = 3'd6,
        CFG_VEL_RATIO = 3'd7
    } t_cfg_idx;

    // classification handed from front to back
    typedef struct packed {
        t_zone zone;
        logic  side;
        logic  a_zero;   // ramp at or below its low edge
        logic  a_one;    // ramp at or past its high edge
    } t_ctl;

endpackage

// ===== rtl/jlztb_front.sv =====
// Front end: accepts a joint, picks zone and side, sets up the ramp quotient.
module jlztb_front
    import jlztb_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int EW          = DEF_VALUE_WIDTH + 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_joint_pos,
    input  logic signed [VALUE_WIDTH-1:0] i_joint_vel,
    input  logic signed [VALUE_WIDTH-1:0] i_task_torque,
    input  logic signed [VALUE_WIDTH-1:0] i_upper_bound,
    input  logic signed [VALUE_WIDTH-1:0] i_lower_bound,
    input  logic        [VALUE_WIDTH-2:0] i_speed_bound,
    input  logic        [VALUE_WIDTH-2:0] i_effort_bound,
    input  logic                          i_has_upper,
    input  logic                          i_has_lower,
    input  logic                          i_enable,
    input  logic        [VALUE_WIDTH-2:0] i_pos_outer,
    input  logic        [VALUE_WIDTH-2:0] i_pos_inner,
    input  logic        [VALUE_WIDTH-2:0] i_vel_outer,
    input  logic        [VALUE_WIDTH-2:0] i_vel_inner,
    output logic                          o_push,
    input  logic                          i_full,
    output logic signed [VALUE_WIDTH-1:0] o_tau,
    output logic signed [VALUE_WIDTH-1:0] o_dq,
    output logic        [VALUE_WIDTH-2:0] o_eb,
    output logic        [EW-1:0]          o_num,
    output logic        [EW-1:0]          o_den,
    output t_ctl                          o_ctl
);

    logic signed [EW-1:0] q, dq, up, lw, vb, pz1, pz2, vz1, vz2;
    logic signed [EW-1:0] z, lo, hi;
    logic                 pv, vv, side;
    t_zone                zone;
    logic                 r_fv;
    logic                 load;

    assign q   = EW'(i_joint_pos);
    assign dq  = EW'(i_joint_vel);
    assign up  = EW'(i_upper_bound);
    assign lw  = EW'(i_lower_bound);
    assign vb  = EW'(i_speed_bound);
    assign pz1 = EW'(i_pos_outer);
    assign pz2 = EW'(i_pos_inner);
    assign vz1 = EW'(i_vel_outer);
    assign vz2 = EW'(i_vel_inner);

    always_comb begin
        pv   = !(i_has_upper && i_has_lower) || ((up - lw) > (pz1 + pz1));
        vv   = vb > (vz1 + vz1);
        zone = ZONE_OFF;
        side = 1'b0;
        if (pv && i_has_upper && (q > up - pz1)) begin
            side = 1'b0;
            zone = (q > up - pz2) ? ZONE_POS_INNER : ZONE_POS_OUTER;
        end
        if (pv && i_has_lower && (q < lw + pz1)) begin
            side = 1'b1;
            zone = (q < lw + pz2) ? ZONE_POS_INNER : ZONE_POS_OUTER;
        end
        // velocity side is skipped when position already claimed that side
        if (vv && (zone == ZONE_OFF || side) && (dq > vb - vz1)) begin
            side = 1'b0;
            zone = (dq > vb - vz2) ? ZONE_VEL_INNER : ZONE_VEL_OUTER;
        end
        if (vv && (zone == ZONE_OFF || !side) && (dq < vz1 - vb)) begin
            side = 1'b1;
            zone = (dq < vz2 - vb) ? ZONE_VEL_INNER : ZONE_VEL_OUTER;
        end
        if (!i_enable) begin
            zone = ZONE_OFF;
            side = 1'b0;
        end
    end

    // ramp operands, mirrored for the lower / negative side
    always_comb begin
        case (zone)
            ZONE_POS_OUTER: begin
                z  = side ? -q : q;
                lo = side ? -(lw + pz1) : up - pz1;
                hi = side ? -(lw + pz2) : up - pz2;
            end
            ZONE_POS_INNER: begin
                z  = side ? -q : q;
                lo = side ? -(lw + pz2) : up - pz2;
                hi = side ? -lw : up;
            end
            ZONE_VEL_OUTER: begin
                z  = side ? -dq : dq;
                lo = vb - vz1;
                hi = vb - vz2;
            end
            ZONE_VEL_INNER: begin
                z  = side ? -dq : dq;
                lo = vb - vz2;
                hi = vb;
            end
            default: begin
                z  = '0;
                lo = '0;
                hi = '0;
            end
        endcase
    end

    assign o_stall = r_fv && i_full;
    assign load    = !o_stall;
    assign o_push  = r_fv && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (load) begin
            r_fv <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            o_tau        <= i_task_torque;
            o_dq         <= i_joint_vel;
            o_eb         <= i_effort_bound;
            o_num        <= EW'(z - lo);
            o_den        <= EW'(hi - lo);
            o_ctl.zone   <= zone;
            o_ctl.side   <= side;
            o_ctl.a_zero <= z <= lo;
            o_ctl.a_one  <= z >= hi;
        end
    end

endmodule

// ===== rtl/jlztb_fifo.sv =====
// Small flip-flop queue between the front and back ends.
module jlztb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4   // power of two
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [PW-1:0]    r_wp, r_rp;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = r_count == CW'(DEPTH);
    assign o_empty = r_count == '0;
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wp <= r_wp + 1'b1;
            if (do_pop)  r_rp <= r_rp + 1'b1;
            if (do_push && !do_pop)      r_count <= r_count + 1'b1;
            else if (do_pop && !do_push) r_count <= r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from empty queue");
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + 1'b1))
        else $error("queue count lost a push");

endmodule

// ===== rtl/jlztb_back.sv =====
// Back end: products, pipelined ramp divider, blend and output register.
module jlztb_back
    import jlztb_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS,
    parameter int EW          = DEF_VALUE_WIDTH + 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_empty,
    output logic                          o_pop,
    input  logic signed [VALUE_WIDTH-1:0] i_tau,
    input  logic signed [VALUE_WIDTH-1:0] i_dq,
    input  logic        [VALUE_WIDTH-2:0] i_eb,
    input  logic        [EW-1:0]          i_num,
    input  logic        [EW-1:0]          i_den,
    input  t_ctl                          i_ctl,
    input  logic        [VALUE_WIDTH-2:0] i_damping,
    input  logic        [RATIO_W-1:0]     i_pos_ratio,
    input  logic        [RATIO_W-1:0]     i_vel_ratio,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [VALUE_WIDTH-1:0] o_avoid_torque,
    output logic        [2:0]             o_zone,
    output logic                          o_side
);

    localparam int W    = VALUE_WIDTH;
    localparam int F    = FRAC_BITS;
    localparam int AW   = F + 1;
    localparam int LAST = F + 4;
    localparam int XW   = (2 * W > IW) ? 2 * W : IW;
    localparam int PW   = W - 1 + RATIO_W;
    localparam logic signed [IW-1:0] OUT_MAX = {{(IW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic signed [IW-1:0] OUT_MIN = ~OUT_MAX;

    function automatic logic signed [IW-1:0] sat_iw(input logic signed [IW-1:0] v);
        logic signed [IW-1:0] r;
        r = v;
        if (v > SAT_LIM)       r = SAT_LIM;
        else if (v < -SAT_LIM) r = -SAT_LIM;
        return r;
    endfunction

    function automatic logic signed [IW-1:0] clampv(input logic signed [IW-1:0] v,
                                                    input logic signed [IW-1:0] b);
        logic signed [IW-1:0] r;
        r = v;
        if (v > b)       r = b;
        else if (v < -b) r = -b;
        return r;
    endfunction

    logic                 adv;
    logic                 r_vld [0:LAST];

    // stage 0 .. F: products and divider steps
    logic signed [W-1:0]  r_tau  [0:F];
    logic signed [IW-1:0] r_damp [0:F];
    logic        [W-1:0]  r_ep   [0:F];
    logic        [W-1:0]  r_ev   [0:F];
    t_ctl                 r_ctl  [0:F];
    logic        [EW-1:0] r_n    [0:F];
    logic        [EW-1:0] r_d    [0:F];
    logic        [F-1:0]  r_q    [0:F];

    logic signed [2*W-1:0] dprod, dsh;
    logic signed [XW-1:0]  dext;
    logic signed [IW-1:0]  damp0;
    logic        [PW-1:0]  epp, evp;

    assign adv   = !r_vld[LAST] || !i_stall;
    assign o_pop = adv && !i_empty;

    assign dprod = $signed({1'b0, i_damping}) * i_dq;
    assign dsh   = dprod >>> F;
    assign dext  = XW'(dsh);
    assign damp0 = (dext > XW'(SAT_LIM))  ? SAT_LIM :
                   (dext < XW'(-SAT_LIM)) ? -SAT_LIM : IW'(dext);
    assign epp   = i_eb * i_pos_ratio;
    assign evp   = i_eb * i_vel_ratio;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (adv) begin
            r_vld[0] <= !i_empty;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_tau[0]  <= i_tau;
            r_damp[0] <= damp0;
            r_ep[0]   <= W'(epp >> RATIO_BITS);
            r_ev[0]   <= W'(evp >> RATIO_BITS);
            r_ctl[0]  <= i_ctl;
            r_n[0]    <= i_num;
            r_d[0]    <= i_den;
            r_q[0]    <= '0;
        end
    end

    // one restoring quotient bit per stage
    for (genvar k = 1; k <= F; k++) begin : g_div
        logic [EW-1:0] n2;
        logic          ge;
        assign n2 = r_n[k-1] << 1;
        assign ge = n2 >= r_d[k-1];

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (adv) begin
                r_vld[k] <= r_vld[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_n[k]    <= ge ? n2 - r_d[k-1] : n2;
                r_q[k]    <= {r_q[k-1][F-2:0], ge};
                r_d[k]    <= r_d[k-1];
                r_tau[k]  <= r_tau[k-1];
                r_damp[k] <= r_damp[k-1];
                r_ep[k]   <= r_ep[k-1];
                r_ev[k]   <= r_ev[k-1];
                r_ctl[k]  <= r_ctl[k-1];
            end
        end
    end

    // stage A: alpha and alpha * ev
    logic        [AW-1:0]   alpha;
    logic        [AW+W-1:0] t2p;
    logic        [AW-1:0]   r_a_alpha;
    logic        [W:0]      r_a_t2;
    logic signed [W-1:0]    r_a_tau;
    logic signed [IW-1:0]   r_a_damp;
    logic        [W-1:0]    r_a_ep, r_a_ev;
    t_ctl                   r_a_ctl;

    assign alpha = r_ctl[F].a_zero ? '0 :
                   r_ctl[F].a_one  ? AW'(1) << F : {1'b0, r_q[F]};
    assign t2p   = alpha * r_ev[F];

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_alpha <= alpha;
            r_a_t2    <= (W+1)'(t2p >> F);
            r_a_tau   <= r_tau[F];
            r_a_damp  <= r_damp[F];
            r_a_ep    <= r_ep[F];
            r_a_ev    <= r_ev[F];
            r_a_ctl   <= r_ctl[F];
        end
    end

    // stage B: per-case blend endpoints
    logic signed [IW-1:0] tau_i, ep_i, ev_i, t2_i, tmd, ndamp, bx, by;
    logic        [AW-1:0] r_b_alpha;
    logic signed [IW-1:0] r_b_x, r_b_diff;
    t_ctl                 r_b_ctl;

    assign tau_i = IW'(r_a_tau);
    assign ep_i  = $signed(IW'(r_a_ep));
    assign ev_i  = $signed(IW'(r_a_ev));
    assign t2_i  = -$signed(IW'(r_a_t2));
    assign tmd   = sat_iw(tau_i - r_a_damp);
    assign ndamp = -r_a_damp;

    always_comb begin
        case (r_a_ctl.zone)
            ZONE_POS_OUTER: begin
                bx = tau_i;
                by = r_a_ctl.side ? clampv(tmd, ev_i) : tmd;
            end
            ZONE_POS_INNER: begin
                bx = tmd;
                by = r_a_ctl.side ? sat_iw(ep_i - r_a_damp) : sat_iw(-ep_i - r_a_damp);
            end
            ZONE_VEL_OUTER: begin
                bx = tau_i;
                by = r_a_ctl.side ? clampv(ndamp, ev_i) : ndamp;
            end
            ZONE_VEL_INNER: begin
                bx = clampv(ndamp, ev_i);
                by = r_a_ctl.side ? ev_i : t2_i;
            end
            default: begin
                bx = '0;
                by = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_b_x     <= bx;
            r_b_diff  <= sat_iw(by - bx);
            r_b_alpha <= r_a_alpha;
            r_b_ctl   <= r_a_ctl;
        end
    end

    // stage C: (y - x) * alpha
    logic signed [IW+AW:0] pm, psh;
    logic signed [IW-1:0]  r_c_x, r_c_m;
    t_ctl                  r_c_ctl;

    assign pm  = r_b_diff * $signed({1'b0, r_b_alpha});
    assign psh = pm >>> F;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c_x   <= r_b_x;
            r_c_m   <= (psh > (IW+AW+1)'(SAT_LIM))  ? SAT_LIM :
                       (psh < (IW+AW+1)'(-SAT_LIM)) ? -SAT_LIM : IW'(psh);
            r_c_ctl <= r_b_ctl;
        end
    end

    // stage D: output register
    logic signed [IW-1:0] sum, res;

    assign sum = sat_iw(r_c_x + r_c_m);
    assign res = (r_c_ctl.zone == ZONE_OFF) ? '0 :
                 (sum > OUT_MAX) ? OUT_MAX :
                 (sum < OUT_MIN) ? OUT_MIN : sum;

    for (genvar k = F + 1; k <= LAST; k++) begin : g_vld
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (adv) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            o_avoid_torque <= W'(res);
            o_zone         <= r_c_ctl.zone;
            o_side         <= r_c_ctl.side;
        end
    end

    assign o_valid = r_vld[LAST];

    a_off_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zone == ZONE_OFF) |-> (o_avoid_torque == '0))
        else $error("torque with no zone");
    a_off_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_zone == ZONE_OFF) |-> !o_side)
        else $error("side set with no zone");
    a_pop_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_vld[0])
        else $error("popped transaction not in pipeline");

endmodule

// ===== rtl/joint_limit_zone_torque_blend.sv =====
// Top level of the joint limit zone torque blend block.
//
// One transaction on the input channel is one joint: position, velocity,
// task torque, limits and limit presence. One transaction leaves on the
// output channel for each: avoidance torque (saturated), zone and side.
// Both channels are valid/stall; a transaction moves at an edge with valid
// high and stall low. Order is kept.
//
// Throughput is one joint per cycle while the receiver does not stall: the
// ramp quotient comes from a divider with one quotient bit per pipeline
// stage, FRAC_BITS stages.
//
// A front stage classifies each joint and hands it to a four-entry queue;
// the back pipeline pops the queue. When the receiver stalls, the back
// pipeline freezes, the queue fills and then o_stall rises to the sender.
//
// Configuration is a valid/ready write port, always ready, index 0..7 as
// enable, position outer/inner zone, velocity outer/inner zone, damping
// gain, position ratio, velocity ratio. Write only while the block is idle.
// Synchronous reset empties the pipeline and queue and loads the default
// register values; no clearing pass is needed.
module joint_limit_zone_torque_blend
    import jlztb_pkg::*;
#(
    parameter int VALUE_WIDTH = DEF_VALUE_WIDTH,
    parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [VALUE_WIDTH-1:0] i_joint_pos,
    input  logic signed [VALUE_WIDTH-1:0] i_joint_vel,
    input  logic signed [VALUE_WIDTH-1:0] i_task_torque,
    input  logic signed [VALUE_WIDTH-1:0] i_upper_bound,
    input  logic signed [VALUE_WIDTH-1:0] i_lower_bound,
    input  logic        [VALUE_WIDTH-2:0] i_speed_bound,
    input  logic        [VALUE_WIDTH-2:0] i_effort_bound,
    input  logic                          i_has_upper,
    input  logic                          i_has_lower,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [VALUE_WIDTH-1:0] o_avoid_torque,
    output logic        [2:0]             o_zone,
    output logic                          o_side,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic        [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [((VALUE_WIDTH > RATIO_W) ? VALUE_WIDTH : RATIO_W)-1:0] i_cfg_data
);

    localparam int W  = VALUE_WIDTH;
    localparam int EW = W + 4;
    localparam int QW = 2 * W + (W - 1) + 2 * EW + $bits(t_ctl);

    // configuration registers
    logic               r_enable;
    logic [W-2:0]       r_pos_outer, r_pos_inner, r_vel_outer, r_vel_inner, r_damping;
    logic [RATIO_W-1:0] r_pos_ratio, r_vel_ratio;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable    <= 1'(RST_ENABLE);
            r_pos_outer <= (W-1)'(RST_POS_OUTER);
            r_pos_inner <= (W-1)'(RST_POS_INNER);
            r_vel_outer <= (W-1)'(RST_VEL_OUTER);
            r_vel_inner <= (W-1)'(RST_VEL_INNER);
            r_damping   <= (W-1)'(RST_DAMPING);
            r_pos_ratio <= RATIO_W'(RST_POS_RATIO);
            r_vel_ratio <= RATIO_W'(RST_VEL_RATIO);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ENABLE:    r_enable    <= i_cfg_data[0];
                CFG_POS_OUTER: r_pos_outer <= i_cfg_data[W-2:0];
                CFG_POS_INNER: r_pos_inner <= i_cfg_data[W-2:0];
                CFG_VEL_OUTER: r_vel_outer <= i_cfg_data[W-2:0];
                CFG_VEL_INNER: r_vel_inner <= i_cfg_data[W-2:0];
                CFG_DAMPING:   r_damping   <= i_cfg_data[W-2:0];
                CFG_POS_RATIO: r_pos_ratio <= i_cfg_data[RATIO_W-1:0];
                CFG_VEL_RATIO: r_vel_ratio <= i_cfg_data[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // front end
    logic                push, full, empty, pop;
    logic signed [W-1:0] f_tau, f_dq, b_tau, b_dq;
    logic        [W-2:0] f_eb, b_eb;
    logic        [EW-1:0] f_num, f_den, b_num, b_den;
    t_ctl                f_ctl, b_ctl;
    logic        [QW-1:0] q_in, q_out;

    jlztb_front #(
        .VALUE_WIDTH (W),
        .EW          (EW)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_joint_pos    (i_joint_pos),
        .i_joint_vel    (i_joint_vel),
        .i_task_torque  (i_task_torque),
        .i_upper_bound  (i_upper_bound),
        .i_lower_bound  (i_lower_bound),
        .i_speed_bound  (i_speed_bound),
        .i_effort_bound (i_effort_bound),
        .i_has_upper    (i_has_upper),
        .i_has_lower    (i_has_lower),
        .i_enable       (r_enable),
        .i_pos_outer    (r_pos_outer),
        .i_pos_inner    (r_pos_inner),
        .i_vel_outer    (r_vel_outer),
        .i_vel_inner    (r_vel_inner),
        .o_push         (push),
        .i_full         (full),
        .o_tau          (f_tau),
        .o_dq           (f_dq),
        .o_eb           (f_eb),
        .o_num          (f_num),
        .o_den          (f_den),
        .o_ctl          (f_ctl)
    );

    // decoupling queue
    assign q_in = {f_tau, f_dq, f_eb, f_num, f_den, f_ctl};
    assign {b_tau, b_dq, b_eb, b_num, b_den, b_ctl} = q_out;

    jlztb_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (q_out)
    );

    // back end
    jlztb_back #(
        .VALUE_WIDTH (W),
        .FRAC_BITS   (FRAC_BITS),
        .EW          (EW)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (empty),
        .o_pop          (pop),
        .i_tau          (b_tau),
        .i_dq           (b_dq),
        .i_eb           (b_eb),
        .i_num          (b_num),
        .i_den          (b_den),
        .i_ctl          (b_ctl),
        .i_damping      (r_damping),
        .i_pos_ratio    (r_pos_ratio),
        .i_vel_ratio    (r_vel_ratio),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_avoid_torque (o_avoid_torque),
        .o_zone         (o_zone),
        .o_side         (o_side)
    );

endmodule
